// File: rtl/llf_pkg.sv
// ----------------------------------------------------------------------------
// llf_pkg - shared definitions for the four-pole ladder low-pass filter
// Widths, arithmetic constants, register indexes and the control-store program.
// ----------------------------------------------------------------------------
package llf_pkg;

	localparam int unsigned SAMPLE_WIDTH_DEF = 24;
	localparam int unsigned NUM_STAGES       = 4;
	localparam int unsigned STG_IDX_W        = $clog2(NUM_STAGES);

	// field and register widths
	localparam int unsigned FS_W       = 18;
	localparam int unsigned FC_W       = 17;
	localparam int unsigned RES_W      = 12;
	localparam int unsigned CMOD_W     = 18;
	localparam int unsigned RMOD_W     = 13;
	localparam int unsigned CFG_DATA_W = 18;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_CUTOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_RES    = 2'd2;

	localparam logic [FS_W-1:0]  SAMPLE_RATE_RST = 18'd48000;
	localparam logic [FC_W-1:0]  BASE_CUTOFF_RST = 17'd1000;
	localparam logic [RES_W-1:0] BASE_RES_RST    = 12'd256;

	// datapath widths
	localparam int unsigned F_W     = 17;   // clamped cutoff, at most 0.45 * fs
	localparam int unsigned FSUM_W  = 19;   // base cutoff + modulation
	localparam int unsigned RSUM_W  = 14;   // base resonance + modulation
	localparam int unsigned KX_W    = 21;   // r * 512 + 2
	localparam int unsigned K_W     = 19;   // feedback gain, Q.16, up to 4.0
	localparam int unsigned PF_W    = 35;   // pi * f, Q.16
	localparam int unsigned DEN_W   = 36;   // fs * 2^16 + pf
	localparam int unsigned NUM_W   = 52;   // pf * 2^16 + den / 2
	localparam int unsigned ALPHA_W = 16;
	localparam int unsigned MULB_W  = 31;
	localparam int unsigned FRAC_SH = 16;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned DIV_ITER = 16;

	localparam logic signed [FSUM_W-1:0] CUTOFF_MIN_HZ = 19'sd20;
	localparam logic signed [RSUM_W-1:0] RES_MAX_Q8    = 14'sd2560;
	localparam logic [KX_W-1:0]          KX_BIAS       = 21'd2;

	// fmax = floor(fs * 45 / 100) = (fs * 45 * ceil(2^31 / 100)) >> 31
	localparam logic signed [MULB_W-1:0] FMAX_MUL   = 31'sd966367665;
	localparam int unsigned              FMAX_SHIFT = 31;
	localparam logic signed [MULB_W-1:0] PI_Q16     = 31'sd205887;
	// k = floor(x / 5) = (x * ceil(2^24 / 5)) >> 24, exact for x < 2^22
	localparam logic signed [MULB_W-1:0] KDIV_MUL   = 31'sd3355444;
	localparam int unsigned              KDIV_SHIFT = 24;

	// control store
	localparam int unsigned STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_MUL_FMAX,
		OP_CLAMP_F,
		OP_MUL_PF,
		OP_DEN,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_COEF,
		OP_MUL_FB,
		OP_DRIVE,
		OP_DIFF,
		OP_MUL_STG,
		OP_UPD_STG,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEXT,      // fall through
		COND_GOTO,      // always jump
		COND_IN,        // hold until an input beat, then fall through
		COND_CNT_NZ,    // jump while loop count is nonzero, else fall through
		COND_OUT_FREE   // hold until the output register can load, then jump
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucode_t;

	localparam step_t ST_WAIT     = 4'd0;
	localparam step_t ST_MUL_FMAX = 4'd1;
	localparam step_t ST_CLAMP_F  = 4'd2;
	localparam step_t ST_MUL_PF   = 4'd3;
	localparam step_t ST_DEN      = 4'd4;
	localparam step_t ST_DIV_LOAD = 4'd5;
	localparam step_t ST_DIV_STEP = 4'd6;
	localparam step_t ST_COEF     = 4'd7;
	localparam step_t ST_MUL_FB   = 4'd8;
	localparam step_t ST_DRIVE    = 4'd9;
	localparam step_t ST_DIFF     = 4'd10;
	localparam step_t ST_MUL_STG  = 4'd11;
	localparam step_t ST_UPD_STG  = 4'd12;
	localparam step_t ST_EMIT     = 4'd13;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t uc;
		unique case (step)
			ST_WAIT:     uc = '{OP_WAIT_IN,  COND_IN,       ST_WAIT};
			ST_MUL_FMAX: uc = '{OP_MUL_FMAX, COND_NEXT,     ST_WAIT};
			ST_CLAMP_F:  uc = '{OP_CLAMP_F,  COND_NEXT,     ST_WAIT};
			ST_MUL_PF:   uc = '{OP_MUL_PF,   COND_NEXT,     ST_WAIT};
			ST_DEN:      uc = '{OP_DEN,      COND_NEXT,     ST_WAIT};
			ST_DIV_LOAD: uc = '{OP_DIV_LOAD, COND_NEXT,     ST_WAIT};
			ST_DIV_STEP: uc = '{OP_DIV_STEP, COND_CNT_NZ,   ST_DIV_STEP};
			ST_COEF:     uc = '{OP_COEF,     COND_NEXT,     ST_WAIT};
			ST_MUL_FB:   uc = '{OP_MUL_FB,   COND_NEXT,     ST_WAIT};
			ST_DRIVE:    uc = '{OP_DRIVE,    COND_NEXT,     ST_WAIT};
			ST_DIFF:     uc = '{OP_DIFF,     COND_NEXT,     ST_WAIT};
			ST_MUL_STG:  uc = '{OP_MUL_STG,  COND_NEXT,     ST_WAIT};
			ST_UPD_STG:  uc = '{OP_UPD_STG,  COND_CNT_NZ,   ST_DIFF};
			ST_EMIT:     uc = '{OP_EMIT,     COND_OUT_FREE, ST_WAIT};
			default:     uc = '{OP_NOP,      COND_GOTO,     ST_WAIT};
		endcase
		return uc;
	endfunction

endpackage

// File: rtl/llf_in_if.sv
// ----------------------------------------------------------------------------
// llf_in_if - input channel of the ladder filter
// One beat carries a sample plus its cutoff and resonance modulation.
// ----------------------------------------------------------------------------
interface llf_in_if
	import llf_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                     valid;
	logic                     ready;
	logic signed [SAMPLE_WIDTH-1:0] audio_in;
	logic signed [CMOD_W-1:0] cutoff_mod_hz;
	logic signed [RMOD_W-1:0] resonance_mod;

	modport source (
		output valid, audio_in, cutoff_mod_hz, resonance_mod,
		input  ready
	);
	modport sink (
		input  valid, audio_in, cutoff_mod_hz, resonance_mod,
		output ready
	);
endinterface

// File: rtl/llf_out_if.sv
// ----------------------------------------------------------------------------
// llf_out_if - output channel of the ladder filter
// One beat carries one filtered sample.
// ----------------------------------------------------------------------------
interface llf_out_if
	import llf_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] audio_out;

	modport source (
		output valid, audio_out,
		input  ready
	);
	modport sink (
		input  valid, audio_out,
		output ready
	);
endinterface

// File: rtl/ladder_lowpass_filter_4pole.sv
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_4pole - four-pole ladder low-pass with resonance
// Microcoded datapath: one shared multiplier, a restoring divider loop and
// four cascaded one-pole stages, sequenced by a small control store.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one Q1.(SAMPLE_WIDTH-1) sample, a signed
// cutoff offset in Hz and a signed Q5.8 resonance offset; each one produces
// exactly one output beat, stage 4 saturated to SAMPLE_WIDTH bits. Cutoff is
// clamped to [20 Hz, 0.45 fs] (upper bound wins if the two cross), resonance
// to [0, 10]; alpha = pi f / (fs + pi f) in Q0.16 and feedback k = 0.4 r.
// Timing: items are handled one at a time, and the next item is taken only
// once the previous result has landed in the output register. The rate is
// set by the 16-iteration restoring divide for alpha (one quotient bit per
// cycle) and by the four stage updates, each a difference, a multiply and
// an update, through the one multiplier. The output register decouples the
// sides: a new item is taken while the previous result still waits.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while
// idle; the block itself does not enforce this. An unknown index is ignored.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_4pole
	import llf_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	llf_in_if.sink                sample_in,
	llf_out_if.source             sample_out
);

	localparam int unsigned SW  = SAMPLE_WIDTH;
	localparam int unsigned STW = SAMPLE_WIDTH + 8;   // stage word, Q9.(SW-1)
	localparam int unsigned DW  = STW + 4;            // drive / difference word
	localparam int unsigned PW  = DW + MULB_W;        // product word

	// ---- saturation helpers -------------------------------------------------
	function automatic logic signed [STW-1:0] sat_stage(input logic signed [DW:0] v);
		logic [DW-STW+1:0] top;
		top = v[DW:STW-1];
		if (&top || ~|top) begin
			return v[STW-1:0];
		end
		return v[DW] ? {1'b1, {(STW-1){1'b0}}} : {1'b0, {(STW-1){1'b1}}};
	endfunction

	function automatic logic signed [SW-1:0] sat_out(input logic signed [STW-1:0] v);
		logic [STW-SW:0] top;
		top = v[STW-1:SW-1];
		if (&top || ~|top) begin
			return v[SW-1:0];
		end
		return v[STW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
	endfunction

	// ---- configuration registers ---------------------------------------------
	logic [FS_W-1:0]  fs_q;
	logic [FC_W-1:0]  fc_q;
	logic [RES_W-1:0] res_q;

	// ---- sequencer -------------------------------------------------------------
	step_t               step_q, step_nx;
	ucode_t              uc;
	logic [CNT_W-1:0]    cnt_q;
	logic [STG_IDX_W-1:0] idx_q;

	// ---- datapath registers ----------------------------------------------------
	logic signed [SW-1:0]     x_q;
	logic signed [CMOD_W-1:0] cmod_q;
	logic signed [RMOD_W-1:0] rmod_q;
	logic signed [PW-1:0]     p_q;       // shared multiplier result
	logic [F_W-1:0]           f_q;
	logic [PF_W-1:0]          pf_q;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W-1:0]         rem_q;
	logic [ALPHA_W-1:0]       quo_q;     // numerator low bits in, quotient bits out
	logic [ALPHA_W-1:0]       alpha_q;
	logic [K_W-1:0]           k_q;
	logic signed [DW-1:0]     drive_q;
	logic signed [DW-1:0]     diff_q;
	logic signed [STW-1:0]    stage_q [NUM_STAGES];
	logic                     out_valid_q;
	logic signed [SW-1:0]     out_data_q;

	// ---- handshakes ------------------------------------------------------------
	logic in_fire, out_free;

	assign uc              = ucode_rom(step_q);
	assign sample_in.ready = (uc.op == OP_WAIT_IN);
	assign in_fire         = sample_in.valid && sample_in.ready;
	// output register can take a new result this cycle
	assign out_free        = !out_valid_q || sample_out.ready;

	assign sample_out.valid     = out_valid_q;
	assign sample_out.audio_out = out_data_q;

	// next step
	always_comb begin
		unique case (uc.cond)
			COND_NEXT:     step_nx = step_q + STEP_W'(1);
			COND_GOTO:     step_nx = uc.target;
			COND_IN:       step_nx = in_fire ? step_q + STEP_W'(1) : step_q;
			COND_CNT_NZ:   step_nx = (cnt_q != '0) ? uc.target : step_q + STEP_W'(1);
			COND_OUT_FREE: step_nx = out_free ? uc.target : step_q;
			default:       step_nx = ST_WAIT;
		endcase
	end

	// ---- shared multiplier operand select ------------------------------------
	logic signed [DW-1:0]     mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic [KX_W-1:0]          kx;
	logic signed [STW-1:0]    stage_last;

	assign stage_last = stage_q[NUM_STAGES-1];

	always_comb begin
		unique case (uc.op)
			OP_MUL_FMAX: begin
				mul_a = $signed({{(DW-FS_W){1'b0}}, fs_q});
				mul_b = FMAX_MUL;
			end
			OP_MUL_PF: begin
				mul_a = $signed({{(DW-F_W){1'b0}}, f_q});
				mul_b = PI_Q16;
			end
			OP_DIV_LOAD: begin
				mul_a = $signed({{(DW-KX_W){1'b0}}, kx});
				mul_b = KDIV_MUL;
			end
			OP_MUL_FB: begin
				mul_a = $signed({{(DW-STW){stage_last[STW-1]}}, stage_last});
				mul_b = $signed({{(MULB_W-K_W){1'b0}}, k_q});
			end
			OP_MUL_STG: begin
				mul_a = diff_q;
				mul_b = $signed({{(MULB_W-ALPHA_W){1'b0}}, alpha_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---- cutoff clamp --------------------------------------------------------
	logic [F_W-1:0]           fmax;
	logic signed [FSUM_W-1:0] fsum, f_lo;
	logic [F_W-1:0]           f_cl;

	assign fmax = p_q[FMAX_SHIFT +: F_W];
	assign fsum = $signed({2'b00, fc_q}) + $signed({cmod_q[CMOD_W-1], cmod_q});
	// lower bound first, upper bound second so it wins when they cross
	assign f_lo = (fsum < CUTOFF_MIN_HZ) ? CUTOFF_MIN_HZ : fsum;
	assign f_cl = (f_lo > $signed({2'b00, fmax})) ? fmax : f_lo[F_W-1:0];

	// ---- resonance clamp and k numerator -------------------------------------
	logic signed [RSUM_W-1:0] rsum;
	logic [RES_W-1:0]         r_cl;

	assign rsum = $signed({2'b00, res_q}) + $signed({rmod_q[RMOD_W-1], rmod_q});

	always_comb begin
		priority if (rsum < 0) begin
			r_cl = '0;
		end else if (rsum > RES_MAX_Q8) begin
			r_cl = RES_MAX_Q8[RES_W-1:0];
		end else begin
			r_cl = rsum[RES_W-1:0];
		end
	end

	assign kx = {r_cl, 9'b0} + KX_BIAS;

	// ---- divider ---------------------------------------------------------------
	logic [DEN_W-1:0] den_d;
	logic [NUM_W-1:0] num;
	logic [DEN_W:0]   div_t, div_sub;
	logic             div_ge;
	logic [DEN_W-1:0] rem_nx;

	assign den_d   = {2'b00, fs_q, 16'h0000} + {1'b0, p_q[PF_W-1:0]};
	assign num     = {1'b0, pf_q, 16'h0000} + {17'h00000, den_q[DEN_W-1:1]};
	assign div_t   = {rem_q, quo_q[ALPHA_W-1]};
	assign div_ge  = (div_t >= {1'b0, den_q});
	assign div_sub = div_t - {1'b0, den_q};
	assign rem_nx  = div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];

	// ---- stage arithmetic ------------------------------------------------------
	logic signed [PW-1:0]  p_rnd;      // round half up, then >> 16
	logic signed [DW-1:0]  drive_d, diff_d;
	logic signed [STW-1:0] stage_sel;
	logic signed [DW:0]    stg_sum;
	logic signed [STW-1:0] stg_sat;

	assign p_rnd     = (p_q + $signed({{(PW-FRAC_SH){1'b0}}, 1'b1, {(FRAC_SH-1){1'b0}}}))
	                   >>> FRAC_SH;
	assign drive_d   = $signed({{(DW-SW){x_q[SW-1]}}, x_q}) - p_rnd[DW-1:0];
	assign stage_sel = stage_q[idx_q];
	assign diff_d    = drive_q - $signed({{(DW-STW){stage_sel[STW-1]}}, stage_sel});
	assign stg_sum   = $signed({{(DW-STW+1){stage_sel[STW-1]}}, stage_sel})
	                 + $signed({p_rnd[DW-1], p_rnd[DW-1:0]});
	assign stg_sat   = sat_stage(stg_sum);

	// ---- control state, configuration and filter state --------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_WAIT;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			fs_q        <= SAMPLE_RATE_RST;
			fc_q        <= BASE_CUTOFF_RST;
			res_q       <= BASE_RES_RST;
			for (int i = 0; i < NUM_STAGES; i++) begin
				stage_q[i] <= '0;
			end
		end else begin
			step_q <= step_nx;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SAMPLE_RATE: fs_q  <= cfg_wdata[FS_W-1:0];
					REG_BASE_CUTOFF: fc_q  <= cfg_wdata[FC_W-1:0];
					REG_BASE_RES:    res_q <= cfg_wdata[RES_W-1:0];
					default: ;
				endcase
			end

			unique case (uc.op)
				OP_DIV_LOAD: cnt_q <= CNT_W'(DIV_ITER - 1);
				OP_DIV_STEP: cnt_q <= cnt_q - CNT_W'(1);
				OP_DRIVE: begin
					cnt_q <= CNT_W'(NUM_STAGES - 1);
					idx_q <= '0;
				end
				OP_UPD_STG: begin
					stage_q[idx_q] <= stg_sat;
					cnt_q          <= cnt_q - CNT_W'(1);
					idx_q          <= idx_q + STG_IDX_W'(1);
				end
				default: ;
			endcase

			if (uc.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (sample_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath payload -------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= sample_in.audio_in;
			cmod_q <= sample_in.cutoff_mod_hz;
			rmod_q <= sample_in.resonance_mod;
		end

		unique case (uc.op)
			OP_MUL_FMAX, OP_MUL_PF, OP_MUL_FB, OP_MUL_STG: p_q <= mul_a * mul_b;
			OP_CLAMP_F: f_q <= f_cl;
			OP_DEN: begin
				pf_q  <= p_q[PF_W-1:0];
				den_q <= den_d;
			end
			OP_DIV_LOAD: begin
				// k numerator goes through the multiplier while the divide runs
				p_q   <= mul_a * mul_b;
				rem_q <= num[NUM_W-1:ALPHA_W];
				quo_q <= num[ALPHA_W-1:0];
			end
			OP_DIV_STEP: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[ALPHA_W-2:0], div_ge};
			end
			OP_COEF: begin
				// zero divisor only with fs = 0 and f = 0: stages hold
				alpha_q <= (den_q == '0) ? '0 : quo_q;
				k_q     <= p_q[KDIV_SHIFT +: K_W];
			end
			OP_DRIVE:   drive_q <= drive_d;
			OP_DIFF:    diff_q  <= diff_d;
			OP_UPD_STG: drive_q <= $signed({{(DW-STW){stg_sat[STW-1]}}, stg_sat});
			OP_EMIT: begin
				if (out_free) begin
					out_data_q <= sat_out(stage_last);
				end
			end
			OP_NOP, OP_WAIT_IN: ;
			default: ;
		endcase
	end

endmodule

// File: rtl/llf_checker.sv
// ----------------------------------------------------------------------------
// llf_checker - port-level checks for the ladder filter
// Tracks items in flight and checks ordering of beats and output holding.
// ----------------------------------------------------------------------------
module llf_checker
	import llf_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] audio_out
);

	logic       in_fire, out_fire;
	logic [1:0] pending_q;   // items taken whose result has not left

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_fire} - {1'b0, out_fire};
		end
	end

	// no result without an item behind it
	a_out_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result beat with no item in flight");

	// a new item is taken only with at most one result still waiting
	a_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> pending_q <= 2'd1)
		else $error("input taken with two items in flight");

	// one item at a time: ready drops right after a beat
	a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input ready right after a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_out))
		else $error("stalled result changed or dropped");

endmodule

bind ladder_lowpass_filter_4pole llf_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_llf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_in.valid),
	.in_ready  (sample_in.ready),
	.out_valid (sample_out.valid),
	.out_ready (sample_out.ready),
	.audio_out (sample_out.audio_out)
);
